/* sv/segment_intersection_classifier_macros.svh */
// Assertion macros for the segment intersection classifier.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_MACROS_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define SIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIC_ASSERT_NOW(lbl, ante, cons, msg)
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/sic_pkg.sv */
// Shared types and constants for the segment intersection classifier.
// No dependencies; imported by every module of the block.
package sic_pkg;

  localparam int DIFF_W  = 33;  // coordinate difference
  localparam int PROD_W  = 66;  // product of two differences
  localparam int CROSS_W = 67;  // cross product, signed
  localparam int MAG_W   = 66;  // cross product magnitude
  localparam int NUM_W   = 99;  // dividend magnitude
  localparam int QUO_W   = 33;  // quotient bits kept before clamping
  localparam int DIV_LAT = QUO_W + 1;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = 36;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_PARALLEL = 3'd0,
    ST_INSIDE   = 3'd1,
    ST_COINCIDE = 3'd2,
    ST_OUT_A    = 3'd3,
    ST_OUT_B    = 3'd4,
    ST_OUT_BOTH = 3'd5
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic [MAG_W-1:0]   den_mag;
    logic [MAG_W-1:0]   na_mag;
    logic [MAG_W-1:0]   nb_mag;
    logic               den_neg;
    logic               na_neg;
    logic               nb_neg;
    logic [DIFF_W-1:0]  dx_mag;
    logic [DIFF_W-1:0]  dy_mag;
    logic               dx_neg;
    logic               dy_neg;
  } sic_entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -SUM_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/sic_front.sv */
// Front part: takes a request, forms the cross products and classifies it.
// Depends on sic_pkg; feeds sic_queue.
module sic_front import sic_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               stall_i,
  input  logic [31:0]        thr_i,
  input  logic signed [31:0] p1_x_i,
  input  logic signed [31:0] p1_y_i,
  input  logic signed [31:0] p2_x_i,
  input  logic signed [31:0] p2_y_i,
  input  logic signed [31:0] p3_x_i,
  input  logic signed [31:0] p3_y_i,
  input  logic signed [31:0] p4_x_i,
  input  logic signed [31:0] p4_y_i,
  output logic               push_o,
  output sic_entry_t         entry_o
);

  localparam int SH = 32 - COORD_WIDTH;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [31:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DIFF_W-1:0] sum_x, sum_y;

  // stage 1
  logic signed [31:0] x1_q, y1_q, mx_q, my_q;
  logic signed [DIFF_W-1:0] dx21_q, dy21_q, dx43_q, dy43_q, dx13_q, dy13_q;
  // stage 2
  logic signed [31:0] x1_2q, y1_2q, mx_2q, my_2q;
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic [DIFF_W-1:0] dxm_2q, dym_2q;
  logic dxn_2q, dyn_2q;
  // stage 3
  logic signed [31:0] x1_3q, y1_3q, mx_3q, my_3q;
  logic signed [CROSS_W-1:0] den_q, na_q, nb_q;
  logic [DIFF_W-1:0] dxm_3q, dym_3q;
  logic dxn_3q, dyn_3q;
  // stage 4
  logic signed [31:0] x1_4q, y1_4q, mx_4q, my_4q;
  logic [MAG_W-1:0] dm_q, am_q, bm_q;
  logic dn_q, an_q, bn_q;
  logic [DIFF_W-1:0] dxm_4q, dym_4q;
  logic dxn_4q, dyn_4q;

  logic [31:0] thr_eff;
  logic sm_d, sm_a, sm_b, out_a, out_b;
  status_e st;

  assign en = !stall_i;

  // Keep the low coordinate bits, sign extended
  assign x1 = (p1_x_i <<< SH) >>> SH;
  assign y1 = (p1_y_i <<< SH) >>> SH;
  assign x2 = (p2_x_i <<< SH) >>> SH;
  assign y2 = (p2_y_i <<< SH) >>> SH;
  assign x3 = (p3_x_i <<< SH) >>> SH;
  assign y3 = (p3_y_i <<< SH) >>> SH;
  assign x4 = (p4_x_i <<< SH) >>> SH;
  assign y4 = (p4_y_i <<< SH) >>> SH;

  assign sum_x = DIFF_W'(x1) + DIFF_W'(x2);
  assign sum_y = DIFF_W'(y1) + DIFF_W'(y2);

  // Advance the valid flags while the queue has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Differences and midpoint
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= x1;
      y1_q   <= y1;
      mx_q   <= sum_x[DIFF_W-1:1];
      my_q   <= sum_y[DIFF_W-1:1];
      dx21_q <= DIFF_W'(x2) - DIFF_W'(x1);
      dy21_q <= DIFF_W'(y2) - DIFF_W'(y1);
      dx43_q <= DIFF_W'(x4) - DIFF_W'(x3);
      dy43_q <= DIFF_W'(y4) - DIFF_W'(y3);
      dx13_q <= DIFF_W'(x1) - DIFF_W'(x3);
      dy13_q <= DIFF_W'(y1) - DIFF_W'(y3);
    end
  end

  // Products
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_2q  <= x1_q;
      y1_2q  <= y1_q;
      mx_2q  <= mx_q;
      my_2q  <= my_q;
      pa_q   <= dy43_q * dx21_q;
      pb_q   <= dx43_q * dy21_q;
      pc_q   <= dx43_q * dy13_q;
      pd_q   <= dy43_q * dx13_q;
      pe_q   <= dx21_q * dy13_q;
      pf_q   <= dy21_q * dx13_q;
      dxm_2q <= dx21_q[DIFF_W-1] ? DIFF_W'(-dx21_q) : DIFF_W'(dx21_q);
      dym_2q <= dy21_q[DIFF_W-1] ? DIFF_W'(-dy21_q) : DIFF_W'(dy21_q);
      dxn_2q <= dx21_q[DIFF_W-1];
      dyn_2q <= dy21_q[DIFF_W-1];
    end
  end

  // Cross products
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_3q  <= x1_2q;
      y1_3q  <= y1_2q;
      mx_3q  <= mx_2q;
      my_3q  <= my_2q;
      den_q  <= CROSS_W'(pa_q) - CROSS_W'(pb_q);
      na_q   <= CROSS_W'(pc_q) - CROSS_W'(pd_q);
      nb_q   <= CROSS_W'(pe_q) - CROSS_W'(pf_q);
      dxm_3q <= dxm_2q;
      dym_3q <= dym_2q;
      dxn_3q <= dxn_2q;
      dyn_3q <= dyn_2q;
    end
  end

  // Magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_4q  <= x1_3q;
      y1_4q  <= y1_3q;
      mx_4q  <= mx_3q;
      my_4q  <= my_3q;
      dm_q   <= den_q[CROSS_W-1] ? MAG_W'(-den_q) : MAG_W'(den_q);
      am_q   <= na_q[CROSS_W-1] ? MAG_W'(-na_q) : MAG_W'(na_q);
      bm_q   <= nb_q[CROSS_W-1] ? MAG_W'(-nb_q) : MAG_W'(nb_q);
      dn_q   <= den_q[CROSS_W-1];
      an_q   <= na_q[CROSS_W-1];
      bn_q   <= nb_q[CROSS_W-1];
      dxm_4q <= dxm_3q;
      dym_4q <= dym_3q;
      dxn_4q <= dxn_3q;
      dyn_4q <= dyn_3q;
    end
  end

  // Classify: negligible tests and range of the exact ratios
  assign thr_eff = (thr_i == 32'd0) ? 32'd1 : thr_i;
  assign sm_d  = (dm_q[MAG_W-1:32] == '0) && (dm_q[31:0] < thr_eff);
  assign sm_a  = (am_q[MAG_W-1:32] == '0) && (am_q[31:0] < thr_eff);
  assign sm_b  = (bm_q[MAG_W-1:32] == '0) && (bm_q[31:0] < thr_eff);
  assign out_a = (am_q != '0) && ((an_q != dn_q) || (am_q > dm_q));
  assign out_b = (bm_q != '0) && ((bn_q != dn_q) || (bm_q > dm_q));

  always_comb begin
    priority if (sm_a && sm_b && sm_d) begin
      st = ST_COINCIDE;
    end else if (sm_d) begin
      st = ST_PARALLEL;
    end else if (out_a && out_b) begin
      st = ST_OUT_BOTH;
    end else if (out_a) begin
      st = ST_OUT_A;
    end else if (out_b) begin
      st = ST_OUT_B;
    end else begin
      st = ST_INSIDE;
    end
  end

  always_comb begin
    entry_o.status  = st;
    entry_o.x1      = x1_4q;
    entry_o.y1      = y1_4q;
    entry_o.mid_x   = mx_4q;
    entry_o.mid_y   = my_4q;
    entry_o.den_mag = dm_q;
    entry_o.na_mag  = am_q;
    entry_o.nb_mag  = bm_q;
    entry_o.den_neg = dn_q;
    entry_o.na_neg  = an_q;
    entry_o.nb_neg  = bn_q;
    entry_o.dx_mag  = dxm_4q;
    entry_o.dy_mag  = dym_4q;
    entry_o.dx_neg  = dxn_4q;
    entry_o.dy_neg  = dyn_4q;
  end

  assign push_o = v4_q && en;

endmodule

/* sv/sic_queue.sv */
// Two-entry queue between the front and back parts.
// Depends on sic_pkg for the entry type; the back part drains it every cycle.
module sic_queue import sic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sic_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  output sic_entry_t entry_o
);

  sic_entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o;
  assign entry_o = mem_q[rd_q];

  // Store a request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

/* sv/sic_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sic_pkg for widths; flags quotients that reach 2^QUO_W.
module sic_div import sic_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] n_i,
  input  logic [MAG_W-1:0] d_i,
  output logic [QUO_W-1:0] q_o,
  output logic             ovf_o
);

  logic [MAG_W-1:0] r_q   [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [MAG_W-1:0] d_q   [QUO_W];
  logic [QUO_W-1:0] q_q   [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  // Load: upper dividend bits form the first partial remainder
  always_ff @(posedge clk_i) begin
    r_q[0]   <= n_i[NUM_W-1:QUO_W];
    lo_q[0]  <= n_i[QUO_W-1:0];
    d_q[0]   <= d_i;
    q_q[0]   <= '0;
    ovf_q[0] <= (n_i[NUM_W-1:QUO_W] >= d_i);
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    logic [MAG_W:0] r2, diff;
    logic           ge;

    assign r2   = {r_q[s-1], lo_q[s-1][QUO_W-1]};
    assign diff = r2 - {1'b0, d_q[s-1]};
    assign ge   = (r2 >= {1'b0, d_q[s-1]});

    // Shift in one quotient bit
    always_ff @(posedge clk_i) begin
      q_q[s]   <= {q_q[s-1][QUO_W-2:0], ge};
      ovf_q[s] <= ovf_q[s-1];
    end

    if (s < QUO_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        r_q[s]  <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
        lo_q[s] <= {lo_q[s-1][QUO_W-2:0], 1'b0};
        d_q[s]  <= d_q[s-1];
      end
    end
  end

  assign q_o   = q_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

/* sv/sic_back.sv */
// Back part: scales numerators, runs the four divisions and forms the result.
// Depends on sic_pkg and sic_div; drains sic_queue one request per cycle.
module sic_back import sic_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sic_entry_t         entry_i,
  output logic               done_o,
  output logic signed [31:0] cross_x_o,
  output logic signed [31:0] cross_y_o,
  output logic signed [31:0] param_a_o,
  output logic signed [31:0] param_b_o,
  output logic [2:0]         status_o
);

  localparam int CHUNK_W = 33;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic               neg_a;
    logic               neg_b;
    logic               neg_x;
    logic               neg_y;
  } meta_t;

  meta_t meta_in;
  meta_t m1_q, m2_q;
  meta_t mc_q [DIV_LAT];
  logic  v1_q, v2_q;
  logic  vc_q [DIV_LAT];

  logic [PROD_W-1:0] tx_lo_q, tx_hi_q, ty_lo_q, ty_hi_q;
  logic [MAG_W-1:0]  am_q, bm_q, dm_q;
  logic [NUM_W-1:0]  na_q, nb_q, nx_q, ny_q;
  logic [MAG_W-1:0]  d2_q;

  logic [QUO_W-1:0]  qa, qb, qx, qy;
  logic              oa, ob, ox, oy;
  logic signed [SUM_W-1:0] sa, sb, sx, sy;
  meta_t             mo;

  logic               done_q;
  logic signed [31:0] cx_q, cy_q, pa_q, pb_q;
  status_e            st_q;

  // Sign of each quotient
  always_comb begin
    meta_in.status = entry_i.status;
    meta_in.x1     = entry_i.x1;
    meta_in.y1     = entry_i.y1;
    meta_in.mid_x  = entry_i.mid_x;
    meta_in.mid_y  = entry_i.mid_y;
    meta_in.neg_a  = entry_i.na_neg ^ entry_i.den_neg;
    meta_in.neg_b  = entry_i.nb_neg ^ entry_i.den_neg;
    meta_in.neg_x  = entry_i.na_neg ^ entry_i.dx_neg ^ entry_i.den_neg;
    meta_in.neg_y  = entry_i.na_neg ^ entry_i.dy_neg ^ entry_i.den_neg;
  end

  // Partial products of numerator a and the segment 1 extent
  always_ff @(posedge clk_i) begin
    m1_q    <= meta_in;
    tx_lo_q <= PROD_W'(entry_i.na_mag[CHUNK_W-1:0]) * PROD_W'(entry_i.dx_mag);
    tx_hi_q <= PROD_W'(entry_i.na_mag[MAG_W-1:CHUNK_W]) * PROD_W'(entry_i.dx_mag);
    ty_lo_q <= PROD_W'(entry_i.na_mag[CHUNK_W-1:0]) * PROD_W'(entry_i.dy_mag);
    ty_hi_q <= PROD_W'(entry_i.na_mag[MAG_W-1:CHUNK_W]) * PROD_W'(entry_i.dy_mag);
    am_q    <= entry_i.na_mag;
    bm_q    <= entry_i.nb_mag;
    dm_q    <= entry_i.den_mag;
  end

  // Assemble the dividends
  always_ff @(posedge clk_i) begin
    m2_q <= m1_q;
    na_q <= NUM_W'(am_q) << FRAC_W;
    nb_q <= NUM_W'(bm_q) << FRAC_W;
    nx_q <= (NUM_W'(tx_hi_q) << CHUNK_W) + NUM_W'(tx_lo_q);
    ny_q <= (NUM_W'(ty_hi_q) << CHUNK_W) + NUM_W'(ty_lo_q);
    d2_q <= dm_q;
  end

  sic_div u_div_a (.clk_i, .n_i(na_q), .d_i(d2_q), .q_o(qa), .ovf_o(oa));
  sic_div u_div_b (.clk_i, .n_i(nb_q), .d_i(d2_q), .q_o(qb), .ovf_o(ob));
  sic_div u_div_x (.clk_i, .n_i(nx_q), .d_i(d2_q), .q_o(qx), .ovf_o(ox));
  sic_div u_div_y (.clk_i, .n_i(ny_q), .d_i(d2_q), .q_o(qy), .ovf_o(oy));

  // Carry side data alongside the dividers
  always_ff @(posedge clk_i) begin
    mc_q[0] <= m2_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      mc_q[i] <= mc_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        vc_q[i] <= 1'b0;
      end
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      vc_q[0] <= v2_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vc_q[i] <= vc_q[i-1];
      end
    end
  end

  // Clamp each quotient, apply its sign
  assign mo = mc_q[DIV_LAT-1];
  assign sa = signed_quot(qa, oa, mo.neg_a);
  assign sb = signed_quot(qb, ob, mo.neg_b);
  assign sx = signed_quot(qx, ox, mo.neg_x);
  assign sy = signed_quot(qy, oy, mo.neg_y);

  function automatic logic signed [SUM_W-1:0] signed_quot(
    input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
    logic [SUM_W-1:0] m;
    m = ovf ? (SUM_W'(1) << QUO_W) : SUM_W'(q);
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Select the result by status
  always_ff @(posedge clk_i) begin
    st_q <= mo.status;
    unique case (mo.status)
      ST_INSIDE, ST_OUT_A, ST_OUT_B, ST_OUT_BOTH: begin
        cx_q <= sat32(SUM_W'(mo.x1) + sx);
        cy_q <= sat32(SUM_W'(mo.y1) + sy);
        pa_q <= sat32(sa);
        pb_q <= sat32(sb);
      end
      ST_COINCIDE: begin
        cx_q <= mo.mid_x;
        cy_q <= mo.mid_y;
        pa_q <= '0;
        pb_q <= '0;
      end
      default: begin
        cx_q <= '0;
        cy_q <= '0;
        pa_q <= '0;
        pb_q <= '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vc_q[DIV_LAT-1];
    end
  end

  assign done_o    = done_q;
  assign cross_x_o = cx_q;
  assign cross_y_o = cy_q;
  assign param_a_o = pa_q;
  assign param_b_o = pb_q;
  assign status_o  = st_q;

endmodule

/* sv/segment_intersection_classifier.sv */
// Top level of the segment intersection classifier: threshold register,
// front, queue and back parts. Depends on sic_pkg and the assertion macros.
//
// Usage
//   A request is taken at a rising edge where start is high and busy is low;
//   its eight coordinates (Q16.16) are sampled at that edge. One result per
//   request leaves on cross_x_o, cross_y_o, param_a_o, param_b_o and
//   status_o, marked by done_o for a single cycle, in request order.
//   The request passes 42 register stages: four front stages (differences,
//   products, cross products, magnitudes, with classification after the
//   last), one in the queue, two to form the dividends, 34 in the pipelined
//   dividers and one output stage. Throughput is one request per cycle while
//   busy is low; the dividers take one quotient bit per stage, so the divider
//   depth sets the latency and not the rate.
//   The receiver cannot hold results off, so the back part drains the queue
//   every cycle and busy stays low in normal use.
//   The threshold register sits at byte address 0 of the APB port and may
//   only be written while no request is in flight.
//   Reset empties the pipeline and the queue and sets the threshold to 43.
`include "segment_intersection_classifier_macros.svh"

module segment_intersection_classifier import sic_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] p1_x_i,
  input  logic signed [31:0] p1_y_i,
  input  logic signed [31:0] p2_x_i,
  input  logic signed [31:0] p2_y_i,
  input  logic signed [31:0] p3_x_i,
  input  logic signed [31:0] p3_y_i,
  input  logic signed [31:0] p4_x_i,
  input  logic signed [31:0] p4_y_i,
  output logic               done_o,
  output logic signed [31:0] cross_x_o,
  output logic signed [31:0] cross_y_o,
  output logic signed [31:0] param_a_o,
  output logic signed [31:0] param_b_o,
  output logic [2:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] thr_q;
  logic        cfg_wr;
  logic        full, push, q_valid;
  sic_entry_t  push_entry, head_entry;

  // Threshold register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? thr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd43;
    end else if (cfg_wr) begin
      thr_q <= pwdata;
    end
  end

  assign busy = full;

  sic_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .start_i (start && !busy),
    .stall_i (full),
    .thr_i   (thr_q),
    .p1_x_i,
    .p1_y_i,
    .p2_x_i,
    .p2_y_i,
    .p3_x_i,
    .p3_y_i,
    .p4_x_i,
    .p4_y_i,
    .push_o  (push),
    .entry_o (push_entry)
  );

  sic_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  sic_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i   (q_valid),
    .entry_i   (head_entry),
    .done_o,
    .cross_x_o,
    .cross_y_o,
    .param_a_o,
    .param_b_o,
    .status_o
  );

  // Parallel and coincident results carry no parameters
  `SIC_ASSERT_NOW(a_parallel_zero, done_o && (status_o == ST_PARALLEL), (cross_x_o == 32'sd0) && (cross_y_o == 32'sd0) && (param_a_o == 32'sd0) && (param_b_o == 32'sd0), "parallel result not zero")
  `SIC_ASSERT_NOW(a_coincide_params, done_o && (status_o == ST_COINCIDE), (param_a_o == 32'sd0) && (param_b_o == 32'sd0), "coincident result has parameters")
  // Inside both segments means both parameters lie in [0, 1]
  `SIC_ASSERT_NOW(a_inside_range, done_o && (status_o == ST_INSIDE), (param_a_o >= 32'sd0) && (param_a_o <= 32'sh10000) && (param_b_o >= 32'sd0) && (param_b_o <= 32'sh10000), "inside result out of range")
  // The queue drains every cycle, so it never stays full
  `SIC_ASSERT_NEXT(a_busy_clears, busy, !busy, "queue stayed full")

endmodule
